/* hw/rtl/crc16d_pkg.sv */
`default_nettype none

package crc16d_pkg;

    localparam logic [7:0]  HDR_FIRST       = 8'hBE;
    localparam logic [7:0]  HDR_SECOND      = 8'hEF;
    localparam logic [7:0]  MAX_FRAME_BYTES = 8'd128;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  BCAST_ID        = 8'd0;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_SEEN = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_crc_byte;
        logic       is_last;
        logic       crc_ok;
        logic       addressed;
    } result_t;

    // CRC-16/ARC, reflected, one byte folded in
    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/crc16d_in_stage.sv */
`default_nettype none

module crc16d_in_stage
    import crc16d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       advance,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

/* hw/rtl/crc16d_core.sv */
`default_nettype none

module crc16d_core
    import crc16d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       node_id_we,
    input  wire logic [6:0] node_id_wdata,
    input  wire logic       step,
    input  wire logic [7:0] ch,
    output logic            res_valid,
    output result_t         res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  target_reg, target_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [6:0]  node_id_reg;

    logic [8:0]  pos;
    logic [8:0]  len9;
    logic [7:0]  target_cur;
    logic        last;
    logic        in_crc_span;

    assign len9        = {1'b0, len_reg};
    assign pos         = {1'b0, cnt_reg} + 9'd1;
    assign last        = pos >= len9;
    // len >= 3 and pos <= len - 2
    assign in_crc_span = (len_reg >= 8'd3) && ((pos + 9'd2) <= len9);
    assign target_cur  = (pos == 9'd1) ? ch : target_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        target_next = target_reg;
        crc_lo_next = crc_lo_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.body_byte = ch;

        unique case (phase_reg)
            PH_HUNT, PH_SEEN:
            begin
                if (ch == HDR_FIRST)
                begin
                    phase_next = PH_SEEN;
                end
                else if (phase_reg == PH_SEEN && ch == HDR_SECOND)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                if (ch >= 8'd1 && ch <= MAX_FRAME_BYTES)
                begin
                    len_next    = ch;
                    cnt_next    = '0;
                    crc_next    = '0;
                    target_next = '0;
                    crc_lo_next = '0;
                    phase_next  = PH_BODY;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                res_valid   = 1'b1;
                cnt_next    = pos[7:0];
                target_next = target_cur;
                if (in_crc_span)
                begin
                    crc_next = crc_arc_byte(crc_reg, ch);
                end
                if ((pos + 9'd1) == len9)
                begin
                    crc_lo_next = ch;
                end
                res.is_crc_byte = (pos + 9'd2) > len9;
                res.is_last     = last;
                if (last)
                begin
                    res.crc_ok    = (len_reg >= 8'd3) && ({ch, crc_lo_reg} == crc_reg);
                    res.addressed = (target_cur == BCAST_ID)
                                 || (target_cur == {1'b0, node_id_reg});
                    phase_next    = PH_HUNT;
                    len_next      = '0;
                    cnt_next      = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            cnt_reg     <= '0;
            crc_reg     <= '0;
            target_reg  <= '0;
            crc_lo_reg  <= '0;
            node_id_reg <= '0;
        end
        else
        begin
            if (node_id_we)
            begin
                node_id_reg <= node_id_wdata;
            end
            if (step)
            begin
                phase_reg  <= phase_next;
                len_reg    <= len_next;
                cnt_reg    <= cnt_next;
                crc_reg    <= crc_next;
                target_reg <= target_next;
                crc_lo_reg <= crc_lo_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/crc16d_out_stage.sv */
`default_nettype none

module crc16d_out_stage
    import crc16d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_res,
    input  wire logic    m_tready,
    output logic         out_valid,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/crc16_serial_packet_deframer.sv */
`default_nettype none

// Framed packet receiver for a serial byte stream. It hunts for the header
// 0xBE 0xEF, takes a length byte of 1 to 128 (anything else drops the frame),
// then passes every body byte out as one request; header and length bytes
// produce nothing. A CRC-16/ARC runs over all body bytes but the last two,
// which carry the expected CRC low byte first. On the final byte (tlast) the
// block flags whether the CRC matched and whether the first body byte was 0
// or node_id; frames of 1 or 2 bytes always report a CRC failure. One byte
// is accepted every clock cycle unless m_tready holds the output back: the
// byte-wide CRC update sits in a single combinational step between the input
// register and the result register. node_id should only be written while no
// frame is in flight.
module crc16_serial_packet_deframer
    import crc16d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        node_id_we,
    input  wire logic [6:0]  node_id_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] body_byte, [8] crc_ok, [9] addressed
    output logic             m_tuser,   // is_crc_byte
    output logic             m_tlast
);

    logic    in_valid;
    logic [7:0] in_byte;
    logic    advance;
    logic    res_valid;
    result_t res;
    logic    out_valid;
    result_t out_res;

    // the stage moves when the output slot is free or being drained
    assign advance = in_valid && (!out_valid || m_tready);

    crc16d_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    crc16d_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_id_we    (node_id_we),
        .node_id_wdata (node_id_wdata),
        .step          (advance),
        .ch            (in_byte),
        .res_valid     (res_valid),
        .res           (res)
    );

    crc16d_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_res  (res),
        .m_tready  (m_tready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'd0, out_res.addressed, out_res.crc_ok, out_res.body_byte};
    assign m_tuser  = out_res.is_crc_byte;
    assign m_tlast  = out_res.is_last;

endmodule

`default_nettype wire
